// ===== src/ffba_pkg.sv =====
// ffba_pkg: shared constants, codes and types of the first-fit block allocator.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package ffba_pkg;

	localparam int MAX_BLOCKS_DEF = 32;
	localparam int SIZE_BITS_DEF  = 16;

	localparam int IDX_FIELD_W  = 5;
	localparam int SIZE_FIELD_W = 16;
	localparam int BC_W         = 6;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 6;

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_REQUEST = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLOCK_COUNT = 1'b0,
		REG_PACK_MODE   = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PUT
	} state_t;

endpackage

// ===== src/ffba_if.sv =====
// ffba_in_if / ffba_out_if: valid/ready channels for input and result words.
// Depends on ffba_pkg for field widths.
`timescale 1ns / 1ps

interface ffba_in_if;
	import ffba_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    op;
	logic [IDX_FIELD_W-1:0]  block_index;
	logic [SIZE_FIELD_W-1:0] size_value;

	modport source (output valid, output op, output block_index, output size_value,
		input ready);
	modport sink (input valid, input op, input block_index, input size_value,
		output ready);
endinterface

interface ffba_out_if;
	import ffba_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    allocated;
	logic [IDX_FIELD_W-1:0]  placed_block;
	logic [SIZE_FIELD_W-1:0] block_size;
	logic [SIZE_FIELD_W-1:0] fragment;

	modport source (output valid, output allocated, output placed_block,
		output block_size, output fragment, input ready);
	modport sink (input valid, input allocated, input placed_block,
		input block_size, input fragment, output ready);
endinterface

// ===== src/ffba_ram.sv =====
// ffba_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ffba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/ffba_fit_unit.sv =====
// ffba_fit_unit: shared subtract/compare unit; tests one table word against a request.
// No dependencies.
`timescale 1ns / 1ps

module ffba_fit_unit #(
	parameter int SIZE_BITS = 16
) (
	input  logic                 pack,
	input  logic                 used,
	input  logic [SIZE_BITS-1:0] cap,
	input  logic [SIZE_BITS-1:0] rem,
	input  logic [SIZE_BITS-1:0] size,
	output logic                 fit,
	output logic [SIZE_BITS-1:0] frag
);

	logic [SIZE_BITS-1:0] opnd;
	logic [SIZE_BITS:0]   diff;

	// exclusive: capacity - request; pack: remaining - request
	assign opnd = pack ? rem : cap;
	assign diff = {1'b0, opnd} - {1'b0, size};
	assign fit  = !diff[SIZE_BITS] && (pack || !used);
	assign frag = diff[SIZE_BITS-1:0];

endmodule

// ===== src/first_fit_block_allocator_core.sv =====
// first_fit_block_allocator_core: first-fit allocator over a block table in one RAM.
// Depends on ffba_pkg, ffba_if, ffba_ram, ffba_fit_unit.
//
//   channel  dir  protocol     word
//   item     in   valid/ready  op, block_index, size_value
//   result   out  valid/ready  allocated, placed_block, block_size, fragment
//   cfg      in   write only   cfg_we, cfg_idx, cfg_data
//
// Load: accepted while idle, no result; ready stays high.
// Request: one table entry per cycle; a hit at entry k ends the scan, a miss reads
//   min(block_count, MAX_BLOCKS) entries (none if zero); busy longer while the result stalls.
// Input is taken only when idle; a pending result waits in the output register
//   while loads are taken. Reset clears control and mode registers, not the table.
`timescale 1ns / 1ps

module first_fit_block_allocator_core #(
	parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
	parameter int SIZE_BITS  = ffba_pkg::SIZE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ffba_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [ffba_pkg::CFG_DATA_W-1:0] cfg_data,
	ffba_in_if.sink                         item,
	ffba_out_if.source                      result
);
	import ffba_pkg::*;

	localparam int IDX_W  = $clog2(MAX_BLOCKS);
	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int WORD_W = 2 * SIZE_BITS + 1;

	state_t state_q, state_d;

	logic [BC_W-1:0]         bc_q;
	logic                    pack_q;
	logic [CNT_W-1:0]        limit;
	logic [CNT_W-1:0]        scan_q;
	logic [IDX_W-1:0]        chk_q;
	logic                    pend_q;
	logic [SIZE_BITS-1:0]    size_q;

	logic                    res_hit_q;
	logic [IDX_FIELD_W-1:0]  res_idx_q;
	logic [SIZE_FIELD_W-1:0] res_cap_q;
	logic [SIZE_FIELD_W-1:0] res_frag_q;

	logic                    out_valid_q;
	logic                    out_hit_q;
	logic [IDX_FIELD_W-1:0]  out_idx_q;
	logic [SIZE_FIELD_W-1:0] out_cap_q;
	logic [SIZE_FIELD_W-1:0] out_frag_q;

	logic                    item_ready;
	logic                    take;
	logic                    take_req;
	logic                    load_ok;
	logic                    issue;
	logic                    done_hit;
	logic                    done_miss;
	logic                    out_free;
	logic                    put;

	logic                    ram_we;
	logic [IDX_W-1:0]        ram_waddr;
	logic [WORD_W-1:0]       ram_wdata;
	logic                    ram_re;
	logic [WORD_W-1:0]       ram_rdata;

	logic                    rd_used;
	logic [SIZE_BITS-1:0]    rd_cap;
	logic [SIZE_BITS-1:0]    rd_rem;
	logic                    fit;
	logic [SIZE_BITS-1:0]    frag;

	always_comb begin
		if (int'(bc_q) > MAX_BLOCKS) begin
			limit = CNT_W'(MAX_BLOCKS);
		end else begin
			limit = CNT_W'(bc_q);
		end
	end

	assign take      = item.valid && item_ready;
	assign take_req  = take && (item.op == OP_REQUEST);
	assign load_ok   = int'(item.block_index) < MAX_BLOCKS;
	assign issue     = (state_q == ST_SCAN) && (scan_q < limit);
	assign done_hit  = (state_q == ST_SCAN) && pend_q && fit;
	assign done_miss = (state_q == ST_SCAN) && pend_q && !fit && !issue;
	assign out_free  = !out_valid_q || result.ready;
	assign put       = (state_q == ST_PUT) && out_free;

	// word layout: used, capacity, remaining
	assign rd_used = ram_rdata[WORD_W-1];
	assign rd_cap  = ram_rdata[2*SIZE_BITS-1:SIZE_BITS];
	assign rd_rem  = ram_rdata[SIZE_BITS-1:0];

	ffba_fit_unit #(
		.SIZE_BITS(SIZE_BITS)
	) u_fit (
		.pack (pack_q),
		.used (rd_used),
		.cap  (rd_cap),
		.rem  (rd_rem),
		.size (size_q),
		.fit  (fit),
		.frag (frag)
	);

	ffba_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_BLOCKS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (scan_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take_req) begin
					state_d = (limit == '0) ? ST_PUT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (done_hit || done_miss) begin
					state_d = ST_PUT;
				end
			end
			ST_PUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		item_ready = 1'b0;
		ram_re     = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = chk_q;
		ram_wdata  = {rd_used, rd_cap, rd_rem};
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (take && (item.op == OP_LOAD) && load_ok) begin
					ram_we    = 1'b1;
					ram_waddr = IDX_W'(item.block_index);
					ram_wdata = {1'b0, SIZE_BITS'(item.size_value),
						SIZE_BITS'(item.size_value)};
				end
			end
			ST_SCAN: begin
				ram_re = issue;
				if (done_hit) begin
					ram_we = 1'b1;
					if (pack_q) begin
						ram_wdata = {rd_used, rd_cap, frag};
					end else begin
						ram_wdata = {1'b1, rd_cap, rd_rem};
					end
				end
			end
			ST_PUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bc_q        <= '0;
			pack_q      <= 1'b1;
			scan_q      <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_idx)
					REG_BLOCK_COUNT: bc_q   <= cfg_data[BC_W-1:0];
					REG_PACK_MODE:   pack_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (take_req) begin
				scan_q <= '0;
				pend_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				if (issue) begin
					scan_q <= scan_q + 1'b1;
				end
				pend_q <= issue && !done_hit;
			end
			if (put) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_req) begin
			size_q     <= SIZE_BITS'(item.size_value);
			res_hit_q  <= 1'b0;
			res_idx_q  <= '0;
			res_cap_q  <= '0;
			res_frag_q <= '0;
		end
		if (issue) begin
			chk_q <= scan_q[IDX_W-1:0];
		end
		if (done_hit) begin
			res_hit_q  <= 1'b1;
			res_idx_q  <= IDX_FIELD_W'(chk_q);
			res_cap_q  <= SIZE_FIELD_W'(rd_cap);
			res_frag_q <= SIZE_FIELD_W'(frag);
		end
		if (put) begin
			out_hit_q  <= res_hit_q;
			out_idx_q  <= res_idx_q;
			out_cap_q  <= res_cap_q;
			out_frag_q <= res_frag_q;
		end
	end

	assign item.ready          = item_ready;
	assign result.valid        = out_valid_q;
	assign result.allocated    = out_hit_q;
	assign result.placed_block = out_idx_q;
	assign result.block_size   = out_cap_q;
	assign result.fragment     = out_frag_q;

	a_scan_write_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && ram_we) |=> (state_q == ST_PUT))
		else $error("table write in scan did not end the scan");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_q)
		else $error("pending read left over in idle");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.allocated) |->
			(result.placed_block == '0 && result.block_size == '0 &&
			result.fragment == '0))
		else $error("miss result carries nonzero fields");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (!item.ready && !ram_we || done_hit))
		else $error("input taken or table written during scan");

endmodule
